// File: rtl/core/bts_pkg.sv
// bts_pkg: shared codes, widths and control structs of the bilinear texture sampler
// no dependencies; imported by every module under rtl/core
package bts_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int CHAN_W     = 8;
  localparam int TEXEL_W    = 3 * CHAN_W;
  localparam int OUT_W      = 16;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;
  localparam int FRAC_W     = 16;
  localparam int ITEM_ADDR_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

  // input item kinds
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [CHAN_W-1:0] FULL_GREEN = 8'd255;

  // tap sequencing: four neighbours per sample
  localparam int TAP_W = 2;
  localparam logic [TAP_W-1:0] TAP_FIRST = 2'd0;
  localparam logic [TAP_W-1:0] TAP_LAST  = 2'd3;

  // result reservation against the output queue
  localparam int RES_W = 2;
  localparam logic [RES_W-1:0] RES_MAX = 2'd2;
  localparam int Q_PTR_W = 1;
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic empty;
  } tap_ctl_t;

  typedef struct packed {
    logic             busy;
    logic [RES_W-1:0] res_cnt;
  } fetch_stat_t;

  typedef struct packed {
    logic             empty;
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] red;
  } result_t;

endpackage

// File: rtl/core/bts_coord.sv
// bts_coord: four-stage elastic pipe that turns u,v fractions into neighbour rows,
// columns and bilinear weights; write items ride along unchanged. uses bts_pkg
module bts_coord
  import bts_pkg::*;
#(
  parameter int MAX_SIDE    = 256,
  parameter int WEIGHT_BITS = 8,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int IDX_W  = $clog2(MAX_SIDE),
  localparam int LIN_W  = IDX_W + SIDE_W,
  localparam int KW     = 2 * WEIGHT_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic                   up_mode,
  input  logic [ITEM_ADDR_W-1:0] up_addr,
  input  logic [TEXEL_W-1:0]     up_rgb,
  input  logic [FRAC_W-1:0]      up_u_frac,
  input  logic [FRAC_W-1:0]      up_v_frac,
  input  logic [SIDE_W-1:0]      side_w,
  input  logic [SIDE_W-1:0]      side_h,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic                   dn_mode,
  output logic [ITEM_ADDR_W-1:0] dn_addr,
  output logic [TEXEL_W-1:0]     dn_rgb,
  output logic                   dn_empty,
  output logic [LIN_W-1:0]       dn_row0,
  output logic [LIN_W-1:0]       dn_row1,
  output logic [IDX_W-1:0]       dn_x0,
  output logic [IDX_W-1:0]       dn_x1,
  output logic [KW-1:0]          dn_k0,
  output logic [KW-1:0]          dn_k1,
  output logic [KW-1:0]          dn_k2,
  output logic [KW-1:0]          dn_k3
);

  localparam int SC_W = FRAC_W + SIDE_W;
  localparam int PW   = 2 * WEIGHT_BITS + 2;
  localparam logic [WEIGHT_BITS:0] WT_ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

  logic rdy1, rdy2, rdy3, rdy4;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  // stage 1: captured item
  logic                   s1_mode_r;
  logic [ITEM_ADDR_W-1:0] s1_addr_r;
  logic [TEXEL_W-1:0]     s1_rgb_r;
  logic [FRAC_W-1:0]      s1_fu_r, s1_fv_r;

  // stage 2: index and weight per axis
  logic                   s2_mode_r, s2_empty_r;
  logic [ITEM_ADDR_W-1:0] s2_addr_r;
  logic [TEXEL_W-1:0]     s2_rgb_r;
  logic [IDX_W-1:0]       s2_x0_r, s2_y0_r;
  logic [WEIGHT_BITS-1:0] s2_wx_r, s2_wy_r;

  // stage 3: wrapped neighbours and corner weights
  logic                   s3_mode_r, s3_empty_r;
  logic [ITEM_ADDR_W-1:0] s3_addr_r;
  logic [TEXEL_W-1:0]     s3_rgb_r;
  logic [IDX_W-1:0]       s3_x0_r, s3_x1_r, s3_y0_r, s3_y1_r;
  logic [KW-1:0]          s3_k_r [4];

  // stage 4: row base addresses
  logic                   s4_mode_r, s4_empty_r;
  logic [ITEM_ADDR_W-1:0] s4_addr_r;
  logic [TEXEL_W-1:0]     s4_rgb_r;
  logic [IDX_W-1:0]       s4_x0_r, s4_x1_r;
  logic [LIN_W-1:0]       s4_row0_r, s4_row1_r;
  logic [KW-1:0]          s4_k_r [4];

  logic [SC_W-1:0]        scaled_u, scaled_v;
  logic [WEIGHT_BITS:0]   omx, omy;
  logic [PW-1:0]          k_full [4];
  logic [SIDE_W-1:0]      x0_inc, y0_inc;
  logic [IDX_W-1:0]       x1, y1;

  assign rdy4     = !s4_v_r || dn_ready;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    scaled_u  = SC_W'(s1_fu_r) * SC_W'(side_w);
    scaled_v  = SC_W'(s1_fv_r) * SC_W'(side_h);
    omx       = WT_ONE - {1'b0, s2_wx_r};
    omy       = WT_ONE - {1'b0, s2_wy_r};
    k_full[0] = PW'(omy) * PW'(omx);
    k_full[1] = PW'(omy) * PW'(s2_wx_r);
    k_full[2] = PW'(s2_wy_r) * PW'(omx);
    k_full[3] = PW'(s2_wy_r) * PW'(s2_wx_r);
    // right and bottom neighbours wrap to column or row zero
    x0_inc    = SIDE_W'(s2_x0_r) + SIDE_W'(1);
    y0_inc    = SIDE_W'(s2_y0_r) + SIDE_W'(1);
    x1        = (x0_inc == side_w) ? '0 : IDX_W'(x0_inc);
    y1        = (y0_inc == side_h) ? '0 : IDX_W'(y0_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= up_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      s1_mode_r <= up_mode;
      s1_addr_r <= up_addr;
      s1_rgb_r  <= up_rgb;
      s1_fu_r   <= up_u_frac;
      s1_fv_r   <= up_v_frac;
    end
    if (rdy2 && s1_v_r) begin
      s2_mode_r  <= s1_mode_r;
      s2_addr_r  <= s1_addr_r;
      s2_rgb_r   <= s1_rgb_r;
      s2_empty_r <= (side_w == '0) || (side_h == '0);
      s2_x0_r    <= scaled_u[FRAC_W +: IDX_W];
      s2_y0_r    <= scaled_v[FRAC_W +: IDX_W];
      s2_wx_r    <= scaled_u[FRAC_W-WEIGHT_BITS +: WEIGHT_BITS];
      s2_wy_r    <= scaled_v[FRAC_W-WEIGHT_BITS +: WEIGHT_BITS];
    end
    if (rdy3 && s2_v_r) begin
      s3_mode_r  <= s2_mode_r;
      s3_addr_r  <= s2_addr_r;
      s3_rgb_r   <= s2_rgb_r;
      s3_empty_r <= s2_empty_r;
      s3_x0_r    <= s2_x0_r;
      s3_x1_r    <= x1;
      s3_y0_r    <= s2_y0_r;
      s3_y1_r    <= y1;
      for (int i = 0; i < 4; i++) begin
        s3_k_r[i] <= KW'(k_full[i]);
      end
    end
    if (rdy4 && s3_v_r) begin
      s4_mode_r  <= s3_mode_r;
      s4_addr_r  <= s3_addr_r;
      s4_rgb_r   <= s3_rgb_r;
      s4_empty_r <= s3_empty_r;
      s4_x0_r    <= s3_x0_r;
      s4_x1_r    <= s3_x1_r;
      s4_row0_r  <= LIN_W'(s3_y0_r) * LIN_W'(side_w);
      s4_row1_r  <= LIN_W'(s3_y1_r) * LIN_W'(side_w);
      for (int i = 0; i < 4; i++) begin
        s4_k_r[i] <= s3_k_r[i];
      end
    end
  end

  assign dn_valid = s4_v_r;
  assign dn_mode  = s4_mode_r;
  assign dn_addr  = s4_addr_r;
  assign dn_rgb   = s4_rgb_r;
  assign dn_empty = s4_empty_r;
  assign dn_row0  = s4_row0_r;
  assign dn_row1  = s4_row1_r;
  assign dn_x0    = s4_x0_r;
  assign dn_x1    = s4_x1_r;
  assign dn_k0    = s4_k_r[0];
  assign dn_k1    = s4_k_r[1];
  assign dn_k2    = s4_k_r[2];
  assign dn_k3    = s4_k_r[3];

endmodule

// File: rtl/core/bts_fetch.sv
// bts_fetch: single-port texel memory with the tap sequencer that issues four reads
// per sample (one for an empty texture) and one write per in-range write item; uses bts_pkg
module bts_fetch
  import bts_pkg::*;
#(
  parameter int MAX_SIDE    = 256,
  parameter int TEXEL_COUNT = 65536,
  parameter int WEIGHT_BITS = 8,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int IDX_W  = $clog2(MAX_SIDE),
  localparam int LIN_W  = IDX_W + SIDE_W,
  localparam int KW     = 2 * WEIGHT_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic                   up_mode,
  input  logic [ITEM_ADDR_W-1:0] up_addr,
  input  logic [TEXEL_W-1:0]     up_rgb,
  input  logic                   up_empty,
  input  logic [LIN_W-1:0]       up_row0,
  input  logic [LIN_W-1:0]       up_row1,
  input  logic [IDX_W-1:0]       up_x0,
  input  logic [IDX_W-1:0]       up_x1,
  input  logic [KW-1:0]          up_k0,
  input  logic [KW-1:0]          up_k1,
  input  logic [KW-1:0]          up_k2,
  input  logic [KW-1:0]          up_k3,
  input  logic                   out_deq,
  output tap_ctl_t               tap_ctl,
  output logic [TEXEL_W-1:0]     tap_rgb,
  output logic [KW-1:0]          tap_k,
  output fetch_stat_t            stat
);

  localparam int ADDR_W = $clog2(TEXEL_COUNT);

  logic [TEXEL_W-1:0] texel_mem [TEXEL_COUNT];
  logic [TEXEL_W-1:0] rd_data_r;

  logic             busy_r, busy_nxt;
  logic [TAP_W-1:0] cnt_r, cnt_nxt;
  logic [RES_W-1:0] res_r, res_nxt;

  logic             cur_empty_r;
  logic [LIN_W-1:0] cur_row_r [2];
  logic [IDX_W-1:0] cur_x_r [2];
  logic [KW-1:0]    cur_k_r [4];

  tap_ctl_t         tap_ctl_r;
  logic [KW-1:0]    tap_k_r;

  logic              last_issue, port_free, res_ok;
  logic              take_write, take_sample, wr_en;
  logic [LIN_W-1:0]  rd_lin;
  logic [ADDR_W-1:0] port_addr;

  assign last_issue  = busy_r && (cnt_r == TAP_LAST);
  assign port_free   = !busy_r || last_issue;
  assign res_ok      = res_r < RES_MAX;
  // writes wait until the sequencer is idle, a sample may follow the last tap directly
  assign up_ready    = (up_mode == MODE_WRITE) ? !busy_r : (port_free && res_ok);
  assign take_write  = up_valid && (up_mode == MODE_WRITE) && !busy_r;
  assign take_sample = up_valid && (up_mode == MODE_SAMPLE) && port_free && res_ok;
  assign wr_en       = take_write && (32'(up_addr) < 32'(TEXEL_COUNT));

  // tap order: (y0,x0) (y0,x1) (y1,x0) (y1,x1)
  assign rd_lin    = cur_row_r[cnt_r[1]] + LIN_W'(cur_x_r[cnt_r[0]]);
  assign port_addr = busy_r ? ADDR_W'(rd_lin) : ADDR_W'(up_addr);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (take_sample) begin
      busy_nxt = 1'b1;
      // empty texture: a single token carries the fallback result
      cnt_nxt  = up_empty ? TAP_LAST : TAP_FIRST;
    end else if (last_issue) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt  = cnt_r + TAP_W'(1);
    end
    res_nxt = res_r + RES_W'(take_sample) - RES_W'(out_deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cnt_r     <= TAP_FIRST;
      res_r     <= '0;
      tap_ctl_r <= '0;
    end else begin
      busy_r          <= busy_nxt;
      cnt_r           <= cnt_nxt;
      res_r           <= res_nxt;
      tap_ctl_r.valid <= busy_r;
      tap_ctl_r.first <= (cnt_r == TAP_FIRST) || cur_empty_r;
      tap_ctl_r.last  <= last_issue;
      tap_ctl_r.empty <= cur_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      cur_empty_r  <= up_empty;
      cur_row_r[0] <= up_row0;
      cur_row_r[1] <= up_row1;
      cur_x_r[0]   <= up_x0;
      cur_x_r[1]   <= up_x1;
      cur_k_r[0]   <= up_k0;
      cur_k_r[1]   <= up_k1;
      cur_k_r[2]   <= up_k2;
      cur_k_r[3]   <= up_k3;
    end
    tap_k_r <= cur_k_r[cnt_r];
  end

  // single-port texel memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      texel_mem[port_addr] <= up_rgb;
    end
    rd_data_r <= texel_mem[port_addr];
  end

  assign tap_ctl      = tap_ctl_r;
  assign tap_rgb      = rd_data_r;
  assign tap_k        = tap_k_r;
  assign stat.busy    = busy_r;
  assign stat.res_cnt = res_r;

endmodule

// File: rtl/core/bts_blend.sv
// bts_blend: weight multiply, four-tap accumulate and the two-entry result queue
// uses bts_pkg; fed by bts_fetch
module bts_blend
  import bts_pkg::*;
#(
  parameter int WEIGHT_BITS = 8,
  localparam int KW = 2 * WEIGHT_BITS + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tap_ctl_t           tap_ctl,
  input  logic [TEXEL_W-1:0] tap_rgb,
  input  logic [KW-1:0]      tap_k,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_res
);

  localparam int SUM_W = CHAN_W + 2 * WEIGHT_BITS;
  localparam int PRW   = CHAN_W + KW;

  tap_ctl_t         prd_ctl_r;
  logic [SUM_W-1:0] prd_r [3];
  logic [SUM_W-1:0] acc_r [3];
  logic [SUM_W-1:0] acc_nxt [3];
  logic [CHAN_W-1:0] chan [3];

  result_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]     q_cnt_r;
  logic                 push, pop;
  result_t              push_res;

  assign chan[0] = tap_rgb[2*CHAN_W +: CHAN_W];
  assign chan[1] = tap_rgb[CHAN_W +: CHAN_W];
  assign chan[2] = tap_rgb[0 +: CHAN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_ctl_r <= '0;
    end else begin
      prd_ctl_r <= tap_ctl;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      // sum of weights is 2^(2*WEIGHT_BITS), so a product always fits SUM_W
      prd_r[c] <= SUM_W'(PRW'(chan[c]) * PRW'(tap_k));
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = prd_ctl_r.first ? prd_r[c] : acc_r[c] + prd_r[c];
    end
    push = prd_ctl_r.valid && prd_ctl_r.last;
    pop  = out_valid && out_ready;
    if (prd_ctl_r.empty) begin
      push_res.empty = 1'b1;
      push_res.red   = '0;
      push_res.green = {FULL_GREEN, {(OUT_W-CHAN_W){1'b0}}};
      push_res.blue  = '0;
    end else begin
      push_res.empty = 1'b0;
      push_res.red   = acc_nxt[0][SUM_W-1 -: OUT_W];
      push_res.green = acc_nxt[1][SUM_W-1 -: OUT_W];
      push_res.blue  = acc_nxt[2][SUM_W-1 -: OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (prd_ctl_r.valid) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
    end
    if (push) begin
      q_r[wr_ptr_r] <= push_res;
    end
  end

  // queue never overflows: the sequencer reserves a slot before a sample starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      q_cnt_r <= q_cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

  assign out_valid = q_cnt_r != '0;
  assign out_res   = q_r[rd_ptr_r];

endmodule

// File: rtl/core/bilinear_texture_sampler.sv
// bilinear_texture_sampler: top level, config registers, coordinate pipe, fetch, blend
// port use: a sample holds the single texel memory port for its four reads, and the next
//   starts with the last read if a result slot is free; a write or empty sample uses it once
// reset: synchronous active-low rst_n clears control state and both sides to zero;
//   texel memory is not cleared and reads are valid only for entries already written
module bilinear_texture_sampler
  import bts_pkg::*;
#(
  parameter int MAX_SIDE    = 256,
  parameter int TEXEL_COUNT = 65536,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // texel_addr[15:0], texel_red[23:16], texel_green[31:24], texel_blue[39:32],
  // coord_u[71:40], coord_v[103:72]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic [0:0]            in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_red[15:0], out_green[31:16], out_blue[47:32]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // empty_texture[0]
  output logic [0:0]            out_tuser,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int LIN_W  = IDX_W + SIDE_W;
  localparam int KW     = 2 * WEIGHT_BITS + 1;

  // config registers
  logic [CFG_DATA_W-1:0] tex_width_r, tex_height_r;
  logic [SIDE_W-1:0]     side_w, side_h;

  // coordinate pipe to fetch
  logic                   cd_valid, cd_ready, cd_mode, cd_empty;
  logic [ITEM_ADDR_W-1:0] cd_addr;
  logic [TEXEL_W-1:0]     cd_rgb;
  logic [LIN_W-1:0]       cd_row0, cd_row1;
  logic [IDX_W-1:0]       cd_x0, cd_x1;
  logic [KW-1:0]          cd_k0, cd_k1, cd_k2, cd_k3;

  // fetch to blend
  tap_ctl_t           tap_ctl;
  logic [TEXEL_W-1:0] tap_rgb;
  logic [KW-1:0]      tap_k;
  fetch_stat_t        fetch_stat;

  result_t res;
  logic    out_deq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= '0;
      tex_height_r <= '0;
    end else if (cfg_we) begin
      // indexes beyond the register list are dropped
      if (cfg_index == REG_TEX_WIDTH)  tex_width_r  <= cfg_wdata;
      if (cfg_index == REG_TEX_HEIGHT) tex_height_r <= cfg_wdata;
    end
  end

  // oversized sides clamp to the largest supported side
  assign side_w = (32'(tex_width_r) > 32'(MAX_SIDE))  ? SIDE_W'(MAX_SIDE) : SIDE_W'(tex_width_r);
  assign side_h = (32'(tex_height_r) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(tex_height_r);

  // coordinate pipe: only the 16-bit fractions matter for repeat wrap
  bts_coord #(
    .MAX_SIDE    (MAX_SIDE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_coord (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .up_mode   (in_tuser[0]),
    .up_addr   (in_tdata[15:0]),
    .up_rgb    (in_tdata[39:16]),
    .up_u_frac (in_tdata[55:40]),
    .up_v_frac (in_tdata[87:72]),
    .side_w    (side_w),
    .side_h    (side_h),
    .dn_valid  (cd_valid),
    .dn_ready  (cd_ready),
    .dn_mode   (cd_mode),
    .dn_addr   (cd_addr),
    .dn_rgb    (cd_rgb),
    .dn_empty  (cd_empty),
    .dn_row0   (cd_row0),
    .dn_row1   (cd_row1),
    .dn_x0     (cd_x0),
    .dn_x1     (cd_x1),
    .dn_k0     (cd_k0),
    .dn_k1     (cd_k1),
    .dn_k2     (cd_k2),
    .dn_k3     (cd_k3)
  );

  // in_tdata texel channels are red, green, blue from the low byte up; the memory
  // word keeps red in the top byte
  logic [TEXEL_W-1:0] cd_rgb_mem;
  assign cd_rgb_mem = {cd_rgb[7:0], cd_rgb[15:8], cd_rgb[23:16]};

  // texel memory and tap sequencer
  bts_fetch #(
    .MAX_SIDE    (MAX_SIDE),
    .TEXEL_COUNT (TEXEL_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cd_valid),
    .up_ready (cd_ready),
    .up_mode  (cd_mode),
    .up_addr  (cd_addr),
    .up_rgb   (cd_rgb_mem),
    .up_empty (cd_empty),
    .up_row0  (cd_row0),
    .up_row1  (cd_row1),
    .up_x0    (cd_x0),
    .up_x1    (cd_x1),
    .up_k0    (cd_k0),
    .up_k1    (cd_k1),
    .up_k2    (cd_k2),
    .up_k3    (cd_k3),
    .out_deq  (out_deq),
    .tap_ctl  (tap_ctl),
    .tap_rgb  (tap_rgb),
    .tap_k    (tap_k),
    .stat     (fetch_stat)
  );

  // weighting, accumulation and result queue
  bts_blend #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap_ctl   (tap_ctl),
    .tap_rgb   (tap_rgb),
    .tap_k     (tap_k),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // one result transaction leaves per dequeue
  assign out_deq      = out_tvalid && out_tready;
  assign out_tdata    = {res.blue, res.green, res.red};
  assign out_tuser[0] = res.empty;

  // reservations never exceed the result queue
  assert property (@(posedge clk) disable iff (!rst_n)
    fetch_stat.res_cnt <= RES_MAX)
    else $error("result reservations exceed queue depth");

  // a queued result always belongs to a reserved sample
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fetch_stat.res_cnt != '0))
    else $error("result offered without a reserved sample");

  // an empty-texture token is a single first-and-last tap
  assert property (@(posedge clk) disable iff (!rst_n)
    (tap_ctl.valid && tap_ctl.empty) |-> (tap_ctl.first && tap_ctl.last))
    else $error("empty-texture token spans more than one tap");

  // a tap token is only produced while the sequencer was busy
  assert property (@(posedge clk) disable iff (!rst_n)
    tap_ctl.valid |-> $past(fetch_stat.busy))
    else $error("tap token without an active sample");

endmodule
